// File: rtl/core/prime_sum_trial_division_assert.svh
// ----------------------------------------------------------------------------
// prime sum assertion macros
// shared concurrent assertion forms for the prime sum checker
// ----------------------------------------------------------------------------
`ifndef PRIME_SUM_TRIAL_DIVISION_ASSERT_SVH
`define PRIME_SUM_TRIAL_DIVISION_ASSERT_SVH

// same-cycle implication, off during reset
`define PSTD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PSTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pstd_pkg.sv
// ----------------------------------------------------------------------------
// prime sum package
// shared constants and sequencer states for the prime sum block
// ----------------------------------------------------------------------------
package pstd_pkg;

  localparam int LIMIT_BITS_DEF = 16;
  localparam int SUM_BITS       = 28;
  // remainder bits resolved per divider cycle
  localparam int RADIX          = 4;
  localparam int FIRST_DIVISOR  = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_DONE
  } state_t;

endpackage

// File: rtl/core/prime_sum_trial_division.sv
// a limit below two goes straight to the result; else each candidate 2..limit is
//   tried in turn: a check and a divide pass per trial, then a last check per prime
// the shared radix-16 remainder unit sets the pace of each trial
// one request at a time: busy is high from accept through the strobe, and the next
// request is taken after it; out_valid is high for one cycle; the receiver cannot stall
// reset: synchronous active-low rst_n returns the sequencer to idle
// ----------------------------------------------------------------------------
// prime sum by trial division
// sums all primes up to an inclusive limit using a shared iterative divider
// ----------------------------------------------------------------------------
module prime_sum_trial_division import pstd_pkg::*; #(
  parameter int LIMIT_BITS = LIMIT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [LIMIT_BITS-1:0] in_limit,
  output logic                  out_valid,
  output logic [SUM_BITS-1:0]   out_prime_sum
);

  localparam int DIV_BITS = (LIMIT_BITS + 1) / 2 + 1;
  localparam int SQ_BITS  = LIMIT_BITS + 2;
  localparam int STEPS    = (LIMIT_BITS + RADIX - 1) / RADIX;
  localparam int PAD_BITS = STEPS * RADIX;
  localparam int CNT_BITS = $clog2(STEPS + 1);

  state_t                state_r,  state_nxt;
  logic [LIMIT_BITS-1:0] lim_r,    lim_nxt;
  logic [LIMIT_BITS-1:0] cand_r,   cand_nxt;
  logic [DIV_BITS-1:0]   div_r,    div_nxt;
  logic [SQ_BITS-1:0]    sq_r,     sq_nxt;
  logic [SUM_BITS-1:0]   acc_r,    acc_nxt;
  logic [DIV_BITS-1:0]   rem_r,    rem_nxt;
  logic [PAD_BITS-1:0]   dvd_r,    dvd_nxt;
  logic [CNT_BITS-1:0]   cnt_r,    cnt_nxt;

  logic [DIV_BITS-1:0]   rem_step;
  logic [PAD_BITS-1:0]   dvd_step;
  logic                  is_last;
  logic                  prime_now;
  logic                  div_last;
  logic                  small_lim;

  // shared divider: RADIX restoring steps per cycle
  always_comb begin
    logic [DIV_BITS:0]   part;
    logic [DIV_BITS-1:0] r;
    logic [PAD_BITS-1:0] q;
    r = rem_r;
    q = dvd_r;
    part = '0;
    for (int i = 0; i < RADIX; i++) begin
      part = {r, q[PAD_BITS-1]};
      q = q << 1;
      if (part >= {1'b0, div_r}) begin
        part = part - {1'b0, div_r};
      end
      r = part[DIV_BITS-1:0];
    end
    rem_step = r;
    dvd_step = q;
  end

  assign is_last   = (cand_r == lim_r);
  // divisor squared beyond candidate: no divisor left, candidate is prime
  assign prime_now = (sq_r > SQ_BITS'(cand_r));
  assign div_last  = (cnt_r == CNT_BITS'(1));
  assign small_lim = (in_limit < LIMIT_BITS'(FIRST_DIVISOR));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = small_lim ? ST_DONE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (prime_now) begin
          state_nxt = is_last ? ST_DONE : ST_CHECK;
        end else begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_last) begin
          state_nxt = ((rem_step == '0) && is_last) ? ST_DONE : ST_CHECK;
        end
      end
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    lim_nxt  = lim_r;
    cand_nxt = cand_r;
    div_nxt  = div_r;
    sq_nxt   = sq_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          lim_nxt  = in_limit;
          cand_nxt = LIMIT_BITS'(FIRST_DIVISOR);
          div_nxt  = DIV_BITS'(FIRST_DIVISOR);
          sq_nxt   = SQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
          acc_nxt  = '0;
        end
      end
      ST_CHECK: begin
        if (prime_now) begin
          acc_nxt = acc_r + SUM_BITS'(cand_r);
          if (!is_last) begin
            cand_nxt = cand_r + LIMIT_BITS'(1);
            div_nxt  = DIV_BITS'(FIRST_DIVISOR);
            sq_nxt   = SQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
          end
        end else begin
          rem_nxt = '0;
          dvd_nxt = PAD_BITS'(cand_r);
          cnt_nxt = CNT_BITS'(STEPS);
        end
      end
      ST_DIVIDE: begin
        rem_nxt = rem_step;
        dvd_nxt = dvd_step;
        cnt_nxt = cnt_r - CNT_BITS'(1);
        if (div_last) begin
          if (rem_step == '0) begin
            if (!is_last) begin
              cand_nxt = cand_r + LIMIT_BITS'(1);
              div_nxt  = DIV_BITS'(FIRST_DIVISOR);
              sq_nxt   = SQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
            end
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            div_nxt = div_r + DIV_BITS'(1);
            sq_nxt  = sq_r + SQ_BITS'({div_r, 1'b1});
          end
        end
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
  end

  assign out_prime_sum = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r  <= lim_nxt;
    cand_r <= cand_nxt;
    div_r  <= div_nxt;
    sq_r   <= sq_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

// File: rtl/core/pstd_checker.sv
// ----------------------------------------------------------------------------
// prime sum port checker
// watches the request and result handshakes of the prime sum block
// ----------------------------------------------------------------------------
`include "prime_sum_trial_division_assert.svh"

module pstd_checker import pstd_pkg::*; #(
  parameter int LIMIT_BITS = LIMIT_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [LIMIT_BITS-1:0] in_limit,
  input logic                  out_valid,
  input logic [SUM_BITS-1:0]   out_prime_sum
);

  logic req_acc;
  logic small_req;

  assign req_acc   = start && !busy;
  assign small_req = (in_limit < LIMIT_BITS'(FIRST_DIVISOR));

  `PSTD_ASSERT_NEXT(a_req_sets_busy, clk, rst_n, req_acc, busy, "busy not set after request")
  `PSTD_ASSERT_SAME(a_valid_while_busy, clk, rst_n, out_valid, busy, "result outside a request")
  `PSTD_ASSERT_NEXT(a_valid_one_cycle, clk, rst_n, out_valid, !out_valid && !busy, "strobe not single")
  `PSTD_ASSERT_SAME(a_busy_ends_on_result, clk, rst_n, $fell(busy), $past(out_valid), "busy dropped without result")
  `PSTD_ASSERT_NEXT(a_small_limit_zero, clk, rst_n, req_acc && small_req, out_valid && (out_prime_sum == '0), "small limit not zero")

endmodule

bind prime_sum_trial_division pstd_checker #(
  .LIMIT_BITS (LIMIT_BITS)
) u_pstd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_limit      (in_limit),
  .out_valid     (out_valid),
  .out_prime_sum (out_prime_sum)
);

// File: tb/prime_sum_trial_division_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime sum by trial division testbench
// drives limits through the start/busy request port, predicts each sum of
// primes by trial division and checks every result strobe against the oldest
// pending sum; a few directed limits, then random limits with and without sender idling
// ----------------------------------------------------------------------------
module prime_sum_trial_division_tb import pstd_pkg::*; ();

  localparam int LIM_W          = LIMIT_BITS_DEF;
  localparam int MAX_CYCLES     = 40_000_000;
  localparam int MAX_SHOWN_ERRS = 10;
  localparam int DRAIN_CYCLES   = 20;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [LIM_W-1:0]    in_limit;
  logic                out_valid;
  logic [SUM_BITS-1:0] out_prime_sum;

  logic [SUM_BITS-1:0] pending_sums[$];
  logic [LIM_W-1:0]    pending_limits[$];
  int                  err_count;
  int                  cycle_count;
  int                  idle_pct;

  prime_sum_trial_division u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_limit     (in_limit),
    .out_valid    (out_valid),
    .out_prime_sum(out_prime_sum)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // sum of all primes up to lim, trial divisors run while d <= v / d
  function automatic logic [SUM_BITS-1:0] prime_sum_upto(input logic [LIM_W-1:0] lim);
    logic [SUM_BITS-1:0] acc;
    int                  v;
    int                  d;
    bit                  no_factor;
    acc = '0;
    for (v = 2; v <= int'(lim); v++) begin
      no_factor = 1'b1;
      for (d = 2; d <= v / d; d++) begin
        if (v % d == 0) begin
          no_factor = 1'b0;
          break;
        end
      end
      if (no_factor) acc = acc + SUM_BITS'(v);
    end
    return acc;
  endfunction

  // one request; start is left high, as the block takes a request on the level of start
  task automatic send_limit(input logic [LIM_W-1:0] lim);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start    <= 1'b1;
    in_limit <= lim;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_sums.push_back(prime_sum_upto(lim));
    pending_limits.push_back(lim);
  endtask

  task automatic test_small_limits();
    logic [LIM_W-1:0] lims[$];
    lims = '{0, 1, 2, 3, 4, 5, 6, 7, 9, 10, 11, 13, 25, 49};
    foreach (lims[i]) send_limit(lims[i]);
  endtask

  task automatic test_field_extremes();
    logic [LIM_W-1:0] lims[$];
    // all-ones limit is the largest limit of the run
    lims = '{100, 255, 256, 1000, {LIM_W{1'b1}}, 0, 1, 1023};
    foreach (lims[i]) send_limit(lims[i]);
  endtask

  task automatic test_random_limits(input int n, input int pct);
    int               sel;
    logic [LIM_W-1:0] lim;
    idle_pct = pct;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 5)       lim = LIM_W'($urandom_range(0, 1));
      else if (sel < 82) lim = LIM_W'($urandom_range(2, 255));
      else if (sel < 97) lim = LIM_W'($urandom_range(256, 2047));
      else               lim = LIM_W'($urandom_range(2048, 8191));
      send_limit(lim);
    end
    idle_pct = 0;
  endtask

  // result checker: the receiver cannot stall, so every strobe is taken
  always @(posedge clk) begin
    logic [SUM_BITS-1:0] want;
    logic [LIM_W-1:0]    lim;
    if (rst_n && out_valid) begin
      if (pending_sums.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN_ERRS)
          $display("unexpected result: prime_sum=%0d", out_prime_sum);
      end else begin
        want = pending_sums.pop_front();
        lim  = pending_limits.pop_front();
        if (out_prime_sum !== want) begin
          err_count++;
          if (err_count <= MAX_SHOWN_ERRS)
            $display("mismatch limit=%0d: prime_sum expected %0d, got %0d",
                     lim, want, out_prime_sum);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_limit    = '0;
    err_count   = 0;
    cycle_count = 0;
    idle_pct    = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_small_limits();
    test_field_extremes();
    test_random_limits(26, 0);
    test_random_limits(26, 47);
    test_random_limits(26, 33);

    @(negedge clk);
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: prime_sum_trial_division.f
+incdir+rtl/core
rtl/core/pstd_pkg.sv
rtl/core/prime_sum_trial_division.sv
rtl/core/pstd_checker.sv
tb/prime_sum_trial_division_tb.sv
